FILE: src/gir_pkg.sv
// ---------------------------------------------------------------------------
// gir_pkg - gamepad input remap package
// Transaction types, unit table entry layout, level codes and hat decode.
// ---------------------------------------------------------------------------
`default_nettype none

package gir_pkg;

  // defaults for the top-level parameters
  localparam int GIR_NUM_UNITS   = 16;
  localparam int GIR_BUTTON_BITS = 64;
  localparam int GIR_NUM_AXES    = 8;
  localparam int GIR_ANALOG_FULL = 255;

  // hardware table depth (entry_index is 4 bits)
  localparam int TABLE_DEPTH = 16;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  localparam logic ROLE_DIGITAL = 1'b0;
  localparam logic ROLE_ANALOG  = 1'b1;

  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_BUTTON = 2'd1;
  localparam logic [1:0] SRC_AXIS   = 2'd2;
  localparam logic [1:0] SRC_HAT    = 2'd3;

  localparam logic [1:0] LVLC_HIGH = 2'd0;
  localparam logic [1:0] LVLC_MID  = 2'd1;
  localparam logic [1:0] LVLC_LOW  = 2'd2;

  localparam logic [7:0] LVL_HIGH = 8'd255;
  localparam logic [7:0] LVL_MID  = 8'd128;
  localparam logic [7:0] LVL_LOW  = 8'd0;

  // possible spans between two distinct levels
  localparam logic [7:0] SPAN_HIGH_LOW = 8'd255;
  localparam logic [7:0] SPAN_MID_LOW  = 8'd128;
  localparam logic [7:0] SPAN_HIGH_MID = 8'd127;

  // floor(x/127) = (x * RECIP_127) >> RECIP_SHIFT for x below 2^15
  localparam logic [15:0] RECIP_127   = 16'd33027;
  localparam int          RECIP_SHIFT = 22;

  typedef struct packed {
    logic        func;
    logic [3:0]  entry_index;
    logic        entry_role;
    logic [1:0]  entry_source_type;
    logic [5:0]  entry_source_number;
    logic [1:0]  entry_on_level;
    logic [1:0]  entry_off_level;
    logic [1:0]  entry_hat_direction;
    logic [63:0] report_buttons;
    logic [63:0] report_axes;
    logic [3:0]  report_hat;
  } in_item_t;

  typedef struct packed {
    logic [3:0] unit_index;
    logic       role;
    logic       pressed;
    logic [7:0] level;
    logic       level_valid;
    logic       last;
  } out_item_t;

  // 15-bit unit table word
  typedef struct packed {
    logic [1:0] hat_dir;
    logic [1:0] off_level;
    logic [1:0] on_level;
    logic [5:0] source_number;
    logic [1:0] source_type;
    logic       role;
  } unit_entry_t;

  function automatic logic [7:0] level_of(input logic [1:0] code);
    logic [7:0] lv;
    case (code)
      LVLC_MID: lv = LVL_MID;
      LVLC_LOW: lv = LVL_LOW;
      default:  lv = LVL_HIGH;
    endcase
    return lv;
  endfunction

  // direction mask per hat code: bit0 left, bit1 right, bit2 up, bit3 down
  function automatic logic hat_match(input logic [3:0] hat, input logic [1:0] dir);
    logic [3:0] mask;
    case (hat)
      4'd0:    mask = 4'h4;
      4'd1:    mask = 4'h6;
      4'd2:    mask = 4'h2;
      4'd3:    mask = 4'hA;
      4'd4:    mask = 4'h8;
      4'd5:    mask = 4'h9;
      4'd6:    mask = 4'h1;
      4'd7:    mask = 4'h5;
      default: mask = 4'h0;
    endcase
    return mask[dir];
  endfunction

endpackage

`default_nettype wire

FILE: src/gamepad_input_remap_top.sv
// ---------------------------------------------------------------------------
// gamepad_input_remap_top - gamepad report remapper
// Unit table in a synchronous memory, walked one entry per cycle through a
// two-stage evaluation pipe that turns raw report data into logical controls.
// ---------------------------------------------------------------------------
// Usage: raise start with a transaction on in_item while busy is low. A load
// transaction (func 0) writes one unit table entry and gives
// no result. A translate transaction (func 1) captures the report and walks
// entries 0 .. N-1, N being units_in_use capped at the table depth; results
// appear on out_item for exactly one cycle each, marked by out_strobe, one per
// cycle, the first after entry 0 passes the table read, both evaluation stages
// and the result register, with last set on the final one. The receiver cannot
// stall, so it must take every strobed result. busy stays high while entries
// of a translate are read, one per cycle through the table's single read port,
// and while the two evaluation stages drain. A translate with N of zero gives
// no result and frees the block at once. Nothing is taken while rst_n is low.
// units_in_use must be written through cfg_we/cfg_wdata only while the block
// is idle; the block does not enforce it. Unit table entries are undefined
// until loaded; walking an unloaded entry gives an arbitrary result.
// ---------------------------------------------------------------------------
`default_nettype none

module gamepad_input_remap_top
  import gir_pkg::*;
#(
  parameter int NUM_UNITS   = GIR_NUM_UNITS,
  parameter int BUTTON_BITS = GIR_BUTTON_BITS,
  parameter int NUM_AXES    = GIR_NUM_AXES,
  parameter int ANALOG_FULL = GIR_ANALOG_FULL
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_strobe,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  // table depth actually used, and widths that follow from it
  localparam int DEPTH = (NUM_UNITS < TABLE_DEPTH) ? NUM_UNITS : TABLE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [7:0]  FULL8  = 8'(ANALOG_FULL);
  localparam logic [15:0] FULL16 = 16'(ANALOG_FULL);

  // ---------------- configuration ----------------
  logic [4:0] units_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_in_use_r <= '0;
    end else if (cfg_we) begin
      units_in_use_r <= cfg_wdata;
    end
  end

  // ---------------- accept ----------------
  logic          acc;
  logic          load_acc;
  logic          xlate_acc;
  logic [CW-1:0] lim_w;

  assign acc       = rst_n && start && !busy;
  assign load_acc  = acc && (in_item.func == FUNC_LOAD);
  assign xlate_acc = acc && (in_item.func == FUNC_XLATE);
  assign lim_w     = (32'(units_in_use_r) < DEPTH) ? CW'(units_in_use_r) : CW'(DEPTH);

  // ---------------- unit table ----------------
  unit_entry_t unit_mem [2**AW];
  unit_entry_t entry_w;
  unit_entry_t rd_data_r;

  assign entry_w = '{hat_dir:       in_item.entry_hat_direction,
                     off_level:     in_item.entry_off_level,
                     on_level:      in_item.entry_on_level,
                     source_number: in_item.entry_source_number,
                     source_type:   in_item.entry_source_type,
                     role:          in_item.entry_role};

  // ---------------- walk sequencer ----------------
  logic          rd_act_r;
  logic [AW-1:0] cnt_r;
  logic [CW-1:0] lim_r;
  logic          rd_last;

  assign rd_last = (CW'(cnt_r) + CW'(1)) == lim_r;

  always_ff @(posedge clk) begin
    if (load_acc && (32'(in_item.entry_index) < DEPTH)) begin
      unit_mem[in_item.entry_index[AW-1:0]] <= entry_w;
    end
    if (rd_act_r) begin
      rd_data_r <= unit_mem[cnt_r];
    end
  end

  // report held for the whole walk
  logic [63:0] rep_buttons_r;
  logic [63:0] rep_axes_r;
  logic [3:0]  rep_hat_r;

  always_ff @(posedge clk) begin
    if (xlate_acc) begin
      rep_buttons_r <= in_item.report_buttons;
      rep_axes_r    <= in_item.report_axes;
      rep_hat_r     <= in_item.report_hat;
      lim_r         <= lim_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0;
      cnt_r    <= '0;
    end else if (xlate_acc) begin
      rd_act_r <= (lim_w != '0);
      cnt_r    <= '0;
    end else if (rd_act_r) begin
      cnt_r <= cnt_r + AW'(1);
      if (rd_last) begin
        rd_act_r <= 1'b0;
      end
    end
  end

  // ---------------- stage 1: decode entry ----------------
  logic          s1_vld_r;
  logic [AW-1:0] s1_idx_r;
  logic          s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= rd_act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_act_r) begin
      s1_idx_r  <= cnt_r;
      s1_last_r <= rd_last;
    end
  end

  logic       btn;
  logic       hat;
  logic [7:0] axv;
  logic [7:0] on_v;
  logic [7:0] off_v;
  logic [7:0] dist_on;
  logic [7:0] dist_off;
  logic       up;
  logic       dir_ok;
  logic [7:0] mag;
  logic [7:0] span;
  logic       s1_pressed;
  logic       s1_valid;
  logic [7:0] s1_level;
  logic       s1_div;

  always_comb begin
    btn   = (32'(rd_data_r.source_number) < BUTTON_BITS) ?
            rep_buttons_r[rd_data_r.source_number] : 1'b0;
    axv   = (32'(rd_data_r.source_number) < NUM_AXES) ?
            rep_axes_r[{rd_data_r.source_number[2:0], 3'b000} +: 8] : 8'd0;
    hat   = hat_match(rep_hat_r, rd_data_r.hat_dir);
    on_v  = level_of(rd_data_r.on_level);
    off_v = level_of(rd_data_r.off_level);

    dist_on  = (on_v > axv)  ? (on_v - axv)  : (axv - on_v);
    dist_off = (off_v > axv) ? (off_v - axv) : (axv - off_v);

    up = on_v > off_v;
    if (up) begin
      dir_ok = axv > off_v;
      mag    = axv - off_v;
      span   = on_v - off_v;
    end else begin
      dir_ok = axv < off_v;
      mag    = off_v - axv;
      span   = off_v - on_v;
    end

    s1_pressed = 1'b0;
    s1_valid   = 1'b0;
    s1_level   = 8'd0;
    s1_div     = 1'b0;
    if (rd_data_r.role == ROLE_DIGITAL) begin
      case (rd_data_r.source_type)
        SRC_BUTTON: s1_pressed = btn;
        SRC_AXIS:   s1_pressed = dist_off > dist_on;
        SRC_HAT:    s1_pressed = hat;
        default:    s1_pressed = 1'b0;
      endcase
    end else begin
      s1_valid = rd_data_r.source_type != SRC_NONE;
      case (rd_data_r.source_type)
        SRC_BUTTON: s1_level = btn ? FULL8 : 8'd0;
        SRC_HAT:    s1_level = hat ? FULL8 : 8'd0;
        SRC_AXIS:   s1_div   = (on_v != off_v) && dir_ok;
        default:    s1_level = 8'd0;
      endcase
    end
  end

  // ---------------- stage 2: axis scaling ----------------
  logic          s2_vld_r;
  logic [AW-1:0] s2_idx_r;
  logic          s2_last_r;
  logic          s2_role_r;
  logic          s2_pressed_r;
  logic          s2_valid_r;
  logic [7:0]    s2_level_r;
  logic          s2_div_r;
  logic [7:0]    s2_mag_r;
  logic [7:0]    s2_span_r;
  logic [15:0]   s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_idx_r     <= s1_idx_r;
      s2_last_r    <= s1_last_r;
      s2_role_r    <= rd_data_r.role;
      s2_pressed_r <= s1_pressed;
      s2_valid_r   <= s1_valid;
      s2_level_r   <= s1_level;
      s2_div_r     <= s1_div;
      s2_mag_r     <= mag;
      s2_span_r    <= span;
      s2_prod_r    <= 16'(mag) * FULL16;
    end
  end

  logic [16:0] q255_sum;
  logic [31:0] q127_prod;
  logic [7:0]  quot;
  logic [7:0]  lvl_out;

  always_comb begin
    q255_sum  = 17'(s2_prod_r) + 17'd1 + 17'(s2_prod_r[15:8]);
    q127_prod = 32'(s2_prod_r) * 32'(RECIP_127);
    case (s2_span_r)
      SPAN_HIGH_LOW: quot = q255_sum[15:8];
      SPAN_MID_LOW:  quot = s2_prod_r[14:7];
      default:       quot = q127_prod[RECIP_SHIFT +: 8];
    endcase
    if (!s2_div_r) begin
      lvl_out = s2_level_r;
    end else if (s2_mag_r >= s2_span_r) begin
      lvl_out = FULL8;     // saturates at full scale
    end else begin
      lvl_out = quot;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      out_item <= '{unit_index:  4'(s2_idx_r),
                    role:        s2_role_r,
                    pressed:     s2_pressed_r,
                    level:       lvl_out,
                    level_valid: s2_valid_r,
                    last:        s2_last_r};
    end
  end

  assign busy = rd_act_r || s1_vld_r || s2_vld_r;

  // ---------------- assertions ----------------
  a_idle_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_strobe)
    else $error("result strobed while idle");

  a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (xlate_acc && (lim_w != '0)) |=> rd_act_r)
    else $error("translate did not start table walk");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |=> !out_strobe)
    else $error("result follows last of a transaction");

  a_valid_analog: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.level_valid) |-> (out_item.role == ROLE_ANALOG))
    else $error("level valid on digital result");

  a_digital_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.role == ROLE_DIGITAL)) |-> (out_item.level == 8'd0))
    else $error("digital result with non-zero level");

  a_analog_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.role == ROLE_ANALOG)) |-> !out_item.pressed)
    else $error("analog result marked pressed");

endmodule

`default_nettype wire
